// ----- sv/ubdc_pkg.sv -----
// shared widths and constants for the uart baud divisor calculator
`timescale 1ns / 1ps
`default_nettype none

package ubdc_pkg;

    localparam int FRACTION_BITS = 6;

    localparam int BAUD_W   = 24;
    localparam int SLOW_W   = 16;
    localparam int FAST_W   = 25;
    localparam int PRE_W    = 16;
    localparam int FM_W     = 4;
    localparam int SM_W     = 8;

    // accepted baud rates are below 2^20, so the divisor needs 20 bits
    localparam int DIV_W    = 20;
    localparam int DVD_W    = FAST_W + FRACTION_BITS;
    localparam int QUOT_W   = DVD_W - FRACTION_BITS;
    localparam int PRE_RAW_W = QUOT_W - FM_W;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    localparam logic [BAUD_W-1:0] MAX_BAUD    = BAUD_W'(1000000);
    localparam logic [SLOW_W-1:0] SLOW_MIN_HZ = SLOW_W'(20000);
    localparam logic [QUOT_W-1:0] OVS_RATIO   = QUOT_W'(16);
    localparam logic [PRE_W-1:0]  PRESCALER_MAX = '1;
    localparam logic [SLOW_W-1:0] SLOW_NOMINAL_RESET = SLOW_W'(32768);

endpackage

`default_nettype wire

// ----- sv/uart_baud_divisor_calc.sv -----
// uart baud divisor calculator: clock choice, pipelined divider and divisor split
//   path: entry stage register, divider stages, then the output register
//   throughput: one request per cycle unless the output stalls; the restoring
//   divider resolves one quotient bit per pipeline stage, DVD_W stages in all
//   a stall at the output freezes every stage, nothing is dropped or repeated
//   reset: all pipeline valid bits clear, slow clock nominal register returns to 32768
`timescale 1ns / 1ps
`default_nettype none

module uart_baud_divisor_calc
    import ubdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_wr_en,
    input  wire logic [SLOW_W-1:0]      cfg_wr_data,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // baud_rate[23:0], slow_clock_measured_hz[39:24], fast_clock_hz[64:40], zero pad
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // rejected[0], clock_select[1], prescaler[17:2], first_modulation[21:18],
    // second_modulation[29:22], oversample[30], range_error[31]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int NDIV = DVD_W;

    logic [SLOW_W-1:0] slow_nominal_reg;

    logic adv;

    // per-stage pipeline registers, index 0 is the entry stage
    logic              valid_reg [0:NDIV];
    logic              rej_reg   [0:NDIV];
    logic              sel_reg   [0:NDIV];
    logic [DIV_W-1:0]  div_reg   [0:NDIV];
    logic [DIV_W-1:0]  rem_reg   [0:NDIV];
    logic [DVD_W-1:0]  dvq_reg   [0:NDIV];

    logic                out_valid_reg;
    logic                out_rej_reg;
    logic                out_sel_reg;
    logic [PRE_W-1:0]    out_pre_reg;
    logic [FM_W-1:0]     out_fm_reg;
    logic [SM_W-1:0]     out_sm_reg;
    logic                out_ovs_reg;
    logic                out_err_reg;

    logic [BAUD_W-1:0]   in_baud;
    logic [SLOW_W-1:0]   in_slow;
    logic [FAST_W-1:0]   in_fast;
    logic [BAUD_W+1:0]   baud_x3;
    logic                in_rej;
    logic                in_sel;
    logic [FAST_W-1:0]   in_clk;

    logic [QUOT_W-1:0]        fin_quot;
    logic [FRACTION_BITS-1:0] fin_frac;
    logic                     fin_ovs;
    logic [PRE_RAW_W-1:0]     fin_pre_raw;
    logic                     fin_err;
    logic [PRE_W-1:0]         out_pre_next;
    logic [FM_W-1:0]          out_fm_next;
    logic [SM_W-1:0]          out_sm_next;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_err_reg, out_ovs_reg, out_sm_reg, out_fm_reg,
                            out_pre_reg, out_sel_reg, out_rej_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_nominal_reg <= SLOW_NOMINAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            slow_nominal_reg <= cfg_wr_data;
        end
    end

    // entry stage: reject check and clock choice
    always_comb
    begin
        in_baud = s_axis_tdata[BAUD_W-1:0];
        in_slow = s_axis_tdata[BAUD_W+SLOW_W-1:BAUD_W];
        in_fast = s_axis_tdata[BAUD_W+SLOW_W+FAST_W-1:BAUD_W+SLOW_W];
        baud_x3 = {1'b0, in_baud, 1'b0} + {2'b00, in_baud};
        in_rej  = (in_baud == '0) || (in_baud > MAX_BAUD);
        in_sel  = !((in_slow > SLOW_MIN_HZ) && ({10'd0, in_slow} >= baud_x3));
        in_clk  = in_sel ? in_fast : FAST_W'(slow_nominal_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rej_reg[0] <= in_rej;
            sel_reg[0] <= in_sel;
            div_reg[0] <= in_baud[DIV_W-1:0];
            rem_reg[0] <= '0;
            dvq_reg[0] <= {in_clk, {FRACTION_BITS{1'b0}}};
        end
    end

    // restoring divider, one quotient bit per stage; dividend bits shift out
    // at the top of dvq while quotient bits shift in at the bottom
    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W:0]   diff;
        logic [DIV_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[g], dvq_reg[g][DVD_W-1]};
            ge       = trial >= {1'b0, div_reg[g]};
            diff     = trial - {1'b0, div_reg[g]};
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rej_reg[g+1] <= rej_reg[g];
                sel_reg[g+1] <= sel_reg[g];
                div_reg[g+1] <= div_reg[g];
                rem_reg[g+1] <= rem_next;
                dvq_reg[g+1] <= {dvq_reg[g][DVD_W-2:0], ge};
            end
        end
    end

    // final stage: split quotient into prescaler and modulation values
    always_comb
    begin
        fin_quot    = dvq_reg[NDIV][DVD_W-1:FRACTION_BITS];
        fin_frac    = dvq_reg[NDIV][FRACTION_BITS-1:0];
        fin_ovs     = fin_quot >= OVS_RATIO;
        fin_pre_raw = fin_ovs ? fin_quot[QUOT_W-1:FM_W] : fin_quot[PRE_RAW_W-1:0];
        fin_err     = fin_pre_raw[PRE_RAW_W-1:PRE_W] != '0;
        out_pre_next = fin_err ? PRESCALER_MAX : fin_pre_raw[PRE_W-1:0];
        out_fm_next  = fin_ovs ? fin_quot[FM_W-1:0] : '0;
        out_sm_next  = SM_W'(fin_frac) << (SM_W - FRACTION_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rej_reg <= rej_reg[NDIV];
            if (rej_reg[NDIV])
            begin
                out_sel_reg <= 1'b0;
                out_pre_reg <= '0;
                out_fm_reg  <= '0;
                out_sm_reg  <= '0;
                out_ovs_reg <= 1'b0;
                out_err_reg <= 1'b0;
            end
            else
            begin
                out_sel_reg <= sel_reg[NDIV];
                out_pre_reg <= out_pre_next;
                out_fm_reg  <= out_fm_next;
                out_sm_reg  <= out_sm_next;
                out_ovs_reg <= fin_ovs;
                out_err_reg <= fin_err;
            end
        end
    end

`ifndef SYNTHESIS
    // a rejected request carries no divisor settings
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rej_reg) |->
            (out_pre_reg == '0 && out_fm_reg == '0 && out_sm_reg == '0 &&
             !out_ovs_reg && !out_err_reg && !out_sel_reg))
        else $error("rejected result has nonzero divisor fields");

    // saturation only happens in oversampling mode and pins the prescaler
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_ovs_reg && out_pre_reg == PRESCALER_MAX))
        else $error("range error without saturated oversampled prescaler");

    // without oversampling the first modulation is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ovs_reg) |-> (out_fm_reg == '0))
        else $error("first modulation set while not oversampling");

    // a stalled pipeline keeps its last stage frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(valid_reg[NDIV]) && $stable(dvq_reg[NDIV])))
        else $error("divider pipeline moved during stall");
`endif

endmodule

`default_nettype wire
